[sv/ede_pkg.sv]
// Shared types and codes for the edit distance engine.
`default_nettype none

package ede_pkg;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_STEP   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    localparam int SYM_W  = 8;
    localparam int DIST_W = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } wave_ctl_t;

endpackage

`default_nettype wire

[sv/edit_distance_engine.sv]
// Top level of the edit distance engine: control, length counters and the cell chain.
`default_nettype none

// Computes the unit-cost Levenshtein distance between a reference string and a
// query string of up to MAX_LEN bytes each. Items carry an action: start clears
// the block, append adds a reference byte, step feeds a query byte and finish
// returns the distance with an overflow flag. A query step sends a wave down a
// chain of MAX_LEN cells, one cell per cycle, and the block takes no new item
// until the wave leaves the last cell; that chain length sets the query rate.
// The result sits in an output register, so items other than finish are taken
// while a result waits. Distances above 127 read as 127.
module edit_distance_engine
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // action [1:0], symbol [9:2], zero [15:10]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // distance [6:0], overflow [7]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int DW = $clog2(MAX_LEN + 1);

    action_t          act;
    logic [SYM_W-1:0] sym;
    logic             accept;
    logic             do_clear;
    logic             append_ok;

    logic [DW-1:0]  qlen_reg;
    logic [DW-1:0]  rlen_reg;
    logic           ovf_reg;
    logic           busy_reg;
    logic [DW-1:0]  dist_reg;
    logic           m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic             launch_valid_reg;
    logic [SYM_W-1:0] launch_sym_reg;
    logic [DW-1:0]    launch_left_reg;
    logic [DW-1:0]    launch_diag_reg;

    wave_ctl_t      chain_ctl  [0:MAX_LEN];
    logic [DW-1:0]  chain_left [0:MAX_LEN];
    logic [DW-1:0]  chain_diag [0:MAX_LEN];
    logic [MAX_LEN:1] load_en;

    logic [DW+7:0]     dist_wide;
    logic [DIST_W-1:0] dist_sat;

    assign act = action_t'(s_tdata[1:0]);
    assign sym = s_tdata[9:2];

    assign s_tready = !busy_reg && (act != ACT_FINISH || !m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign do_clear = accept && act == ACT_START;
    assign append_ok = accept && act == ACT_APPEND && qlen_reg == '0
                       && rlen_reg != DW'(MAX_LEN);

    assign dist_wide = (DW+8)'(dist_reg);
    assign dist_sat  = (dist_wide > (DW+8)'(127)) ? DIST_W'(127) : dist_wide[DIST_W-1:0];

    assign chain_ctl[0]  = {launch_valid_reg, launch_sym_reg};
    assign chain_left[0] = launch_left_reg;
    assign chain_diag[0] = launch_diag_reg;

    for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
        assign load_en[j] = append_ok && rlen_reg == DW'(j - 1);

        ede_cell #(
            .DW (DW),
            .J  (j)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clear    (do_clear),
            .load     (load_en[j]),
            .load_sym (sym),
            .in_ctl   (chain_ctl[j-1]),
            .in_left  (chain_left[j-1]),
            .in_diag  (chain_diag[j-1]),
            .out_ctl  (chain_ctl[j]),
            .out_left (chain_left[j]),
            .out_diag (chain_diag[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlen_reg         <= '0;
            rlen_reg         <= '0;
            ovf_reg          <= 1'b0;
            busy_reg         <= 1'b0;
            dist_reg         <= '0;
            m_valid_reg      <= 1'b0;
            launch_valid_reg <= 1'b0;
        end else begin
            launch_valid_reg <= 1'b0;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (chain_ctl[MAX_LEN].valid) begin
                busy_reg <= 1'b0;
                dist_reg <= chain_left[MAX_LEN];
            end
            if (accept) begin
                case (act)
                    ACT_START: begin
                        qlen_reg <= '0;
                        rlen_reg <= '0;
                        ovf_reg  <= 1'b0;
                        dist_reg <= '0;
                    end
                    ACT_APPEND: begin
                        if (qlen_reg == '0) begin
                            if (rlen_reg == DW'(MAX_LEN)) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                rlen_reg <= rlen_reg + DW'(1);
                                dist_reg <= rlen_reg + DW'(1);
                            end
                        end
                    end
                    ACT_STEP: begin
                        if (qlen_reg == DW'(MAX_LEN)) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            qlen_reg         <= qlen_reg + DW'(1);
                            busy_reg         <= 1'b1;
                            launch_valid_reg <= 1'b1;
                        end
                    end
                    ACT_FINISH: begin
                        m_valid_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && act == ACT_STEP) begin
            launch_sym_reg  <= sym;
            launch_left_reg <= qlen_reg + DW'(1);
            launch_diag_reg <= qlen_reg;
        end
        if (accept && act == ACT_FINISH) begin
            m_data_reg <= {ovf_reg, dist_sat};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[sv/ede_cell.sv]
// One cell of the edit distance chain: a reference byte and one entry of the row.
`default_nettype none

module ede_cell
    import ede_pkg::*;
#(
    parameter int DW = 7,
    parameter int J  = 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                clear,
    input  wire logic                load,
    input  wire logic [SYM_W-1:0]    load_sym,
    input  wire wave_ctl_t           in_ctl,
    input  wire logic [DW-1:0]       in_left,
    input  wire logic [DW-1:0]       in_diag,
    output wave_ctl_t                out_ctl,
    output logic [DW-1:0]            out_left,
    output logic [DW-1:0]            out_diag
);

    logic             has_ref_reg;
    logic [SYM_W-1:0] ref_reg;
    logic [DW-1:0]    dp_reg;
    logic [DW-1:0]    dp_next;
    logic             out_valid_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic [DW-1:0]    out_left_reg;
    logic [DW-1:0]    out_diag_reg;

    logic [DW:0] up_inc;
    logic [DW:0] left_inc;
    logic [DW:0] diag_cost;
    logic [DW:0] min_ab;
    logic [DW:0] min_all;

    always_comb begin
        up_inc    = {1'b0, dp_reg} + (DW+1)'(1);
        left_inc  = {1'b0, in_left} + (DW+1)'(1);
        diag_cost = {1'b0, in_diag} + (DW+1)'(ref_reg != in_ctl.sym);
        min_ab    = (up_inc < left_inc) ? up_inc : left_inc;
        min_all   = (min_ab < diag_cost) ? min_ab : diag_cost;
        dp_next   = min_all[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_ref_reg   <= 1'b0;
            dp_reg        <= DW'(J);
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_ctl.valid;
            if (clear) begin
                has_ref_reg <= 1'b0;
                dp_reg      <= DW'(J);
            end else if (load) begin
                has_ref_reg <= 1'b1;
            end else if (in_ctl.valid && has_ref_reg) begin
                dp_reg <= dp_next;
            end
        end
    end

    // Past the last reference byte the wave passes through unchanged, so the
    // end of the chain sees the row entry at the reference length.
    always_ff @(posedge aclk) begin
        if (load) begin
            ref_reg <= load_sym;
        end
        out_sym_reg <= in_ctl.sym;
        if (has_ref_reg) begin
            out_left_reg <= dp_next;
            out_diag_reg <= dp_reg;
        end else begin
            out_left_reg <= in_left;
            out_diag_reg <= in_diag;
        end
    end

    assign out_ctl  = {out_valid_reg, out_sym_reg};
    assign out_left = out_left_reg;
    assign out_diag = out_diag_reg;

endmodule

`default_nettype wire
